[rtl/tiu_pkg.sv]
// Shared types and constants for the timer and interrupt unit.
// Depends on nothing; used by tiu_timer and timer_and_interrupt_unit.
package tiu_pkg;

    localparam int unsigned CYCLES_W  = 6;
    localparam int unsigned IRQ_W     = 5;
    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned PERIOD_W  = 11;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 11'd1024;
    localparam logic [PERIOD_W-1:0] ACCUM_MAX     = 11'd2047;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 8'hFF;
    localparam logic [IRQ_W-1:0]    TIMER_REQ     = 5'b00100;
    localparam logic [ADDR_W-1:0]   VECTOR_BASE   = 16'h0040;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMER_ENABLE   = 2'd0,
        REG_TIMER_PERIOD   = 2'd1,
        REG_TIMER_RELOAD   = 2'd2,
        REG_INTERRUPT_MASK = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                enable;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  reload;
    } timer_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] timer_count;
        logic [COUNT_W-1:0] divider_count;
        logic               overflow;
    } timer_status_t;

endpackage

[rtl/tiu_timer.sv]
// Timer and divider counters with their cycle accumulators.
// Depends on tiu_pkg; reports the counts after the current step.
module tiu_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [tiu_pkg::CYCLES_W-1:0]  cycles,
    input  tiu_pkg::timer_cfg_t           cfg,
    output tiu_pkg::timer_status_t        status
);
    import tiu_pkg::*;

    logic [PERIOD_W-1:0] timer_accum_reg, timer_accum_next;
    logic [COUNT_W-1:0]  timer_count_reg, timer_count_next;
    logic [COUNT_W-1:0]  divider_accum_reg, divider_accum_next;
    logic [COUNT_W-1:0]  divider_count_reg, divider_count_next;

    logic [PERIOD_W:0]   sum;
    logic [PERIOD_W:0]   remainder;
    logic                hit;
    logic                overflow;
    logic [COUNT_W:0]    div_sum;

    always_comb
    begin
        sum       = {1'b0, timer_accum_reg} + {{(PERIOD_W + 1 - CYCLES_W){1'b0}}, cycles};
        hit       = sum >= {1'b0, cfg.period};
        remainder = hit ? sum - {1'b0, cfg.period} : sum;

        timer_accum_next = timer_accum_reg;
        timer_count_next = timer_count_reg;
        overflow         = 1'b0;
        if (cfg.enable)
        begin
            // saturate the accumulator when the remainder overflows its width
            timer_accum_next = remainder[PERIOD_W] ? ACCUM_MAX : remainder[PERIOD_W-1:0];
            if (hit)
            begin
                if (timer_count_reg == COUNT_MAX)
                begin
                    timer_count_next = cfg.reload;
                    overflow         = 1'b1;
                end
                else
                begin
                    timer_count_next = timer_count_reg + COUNT_W'(1);
                end
            end
        end

        // divider moves once per 256 gathered cycles: carry out of the low byte
        div_sum            = {1'b0, divider_accum_reg} + {{(COUNT_W + 1 - CYCLES_W){1'b0}}, cycles};
        divider_accum_next = div_sum[COUNT_W-1:0];
        divider_count_next = divider_count_reg + {{(COUNT_W - 1){1'b0}}, div_sum[COUNT_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_accum_reg   <= '0;
            timer_count_reg   <= '0;
            divider_accum_reg <= '0;
            divider_count_reg <= '0;
        end
        else if (step)
        begin
            timer_accum_reg   <= timer_accum_next;
            timer_count_reg   <= timer_count_next;
            divider_accum_reg <= divider_accum_next;
            divider_count_reg <= divider_count_next;
        end
    end

    assign status.timer_count   = timer_count_next;
    assign status.divider_count = divider_count_next;
    assign status.overflow      = overflow;

endmodule

[rtl/timer_and_interrupt_unit.sv]
// Timer and interrupt unit: one CPU step word in, one result word out.
// Path: a word passes the input register, then the result register, where out_valid rises;
// out_stall can hold it in the input register; the timer and pending state advance per word.
// Throughput: one word per cycle while out_stall is low.
// Reset (rst_n, async low): config to defaults (period 1024), counters, pending and valids clear.
// Depends on tiu_pkg and tiu_timer.
module timer_and_interrupt_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tiu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tiu_pkg::CFG_DATA_W-1:0]  cfg_data,
    // step input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tiu_pkg::CYCLES_W-1:0]    elapsed_cycles,
    input  logic [tiu_pkg::IRQ_W-1:0]       external_requests,
    input  logic                            master_enable,
    input  logic [tiu_pkg::ADDR_W-1:0]      program_counter,
    input  logic [tiu_pkg::ADDR_W-1:0]      stack_pointer,
    input  logic                            halted,
    // step result
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            take_interrupt,
    output logic [tiu_pkg::ADDR_W-1:0]      new_pc,
    output logic [tiu_pkg::ADDR_W-1:0]      new_sp,
    output logic [tiu_pkg::COUNT_W-1:0]     push_high,
    output logic [tiu_pkg::COUNT_W-1:0]     push_low,
    output logic                            enable_out,
    output logic                            halted_out,
    output logic [tiu_pkg::COUNT_W-1:0]     timer_value,
    output logic [tiu_pkg::COUNT_W-1:0]     divider_value,
    output logic [tiu_pkg::IRQ_W-1:0]       pending_out
);
    import tiu_pkg::*;

    // lowest set request index; bit four is served only when bits zero to three are clear
    function automatic logic [2:0] lowest_index(input logic [IRQ_W-1:0] req);
        logic [2:0] idx;
        if (req[0])      idx = 3'd0;
        else if (req[1]) idx = 3'd1;
        else if (req[2]) idx = 3'd2;
        else if (req[3]) idx = 3'd3;
        else             idx = 3'd4;
        return idx;
    endfunction

    // ---------------- configuration registers ----------------
    timer_cfg_t          timer_cfg_reg;
    logic [IRQ_W-1:0]    interrupt_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_cfg_reg.enable <= 1'b0;
            timer_cfg_reg.period <= PERIOD_RESET;
            timer_cfg_reg.reload <= '0;
            interrupt_mask_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_TIMER_ENABLE:   timer_cfg_reg.enable <= cfg_data[0];
                REG_TIMER_PERIOD:   timer_cfg_reg.period <= cfg_data[PERIOD_W-1:0];
                REG_TIMER_RELOAD:   timer_cfg_reg.reload <= cfg_data[COUNT_W-1:0];
                REG_INTERRUPT_MASK: interrupt_mask_reg   <= cfg_data[IRQ_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------- handshake control ----------------
    // The result register frees up when empty or when its word is taken this cycle;
    // the input register then advances, so a new word can enter every cycle while out_stall is low.
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic load_s1;
    logic move;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign load_s1  = in_valid && !in_stall;
    assign move     = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next  = load_s1 || (s1_valid_reg && !move);
        out_valid_next = move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- input register ----------------
    logic [CYCLES_W-1:0] s1_cycles_reg;
    logic [IRQ_W-1:0]    s1_ext_reg;
    logic                s1_ime_reg;
    logic [ADDR_W-1:0]   s1_pc_reg;
    logic [ADDR_W-1:0]   s1_sp_reg;
    logic                s1_halt_reg;

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_cycles_reg <= elapsed_cycles;
            s1_ext_reg    <= external_requests;
            s1_ime_reg    <= master_enable;
            s1_pc_reg     <= program_counter;
            s1_sp_reg     <= stack_pointer;
            s1_halt_reg   <= halted;
        end
    end

    // ---------------- timer and divider ----------------
    timer_status_t timer_status;

    tiu_timer u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (move),
        .cycles (s1_cycles_reg),
        .cfg    (timer_cfg_reg),
        .status (timer_status)
    );

    // ---------------- interrupt service ----------------
    logic [IRQ_W-1:0]  pending_reg, pending_next;
    logic [IRQ_W-1:0]  pending_merged;
    logic [IRQ_W-1:0]  active;
    logic [2:0]        serve_idx;
    logic              take;
    logic [ADDR_W-1:0] vector;

    always_comb
    begin
        pending_merged = pending_reg | s1_ext_reg | (timer_status.overflow ? TIMER_REQ : '0);
        active         = pending_merged & interrupt_mask_reg;
        take           = (|active) && s1_ime_reg;
        serve_idx      = lowest_index(active);
        vector         = VECTOR_BASE + {{(ADDR_W - 6){1'b0}}, serve_idx, 3'b000};
        // drop the served flag
        pending_next   = take ? pending_merged & ~(IRQ_W'(1) << serve_idx) : pending_merged;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (move)
        begin
            pending_reg <= pending_next;
        end
    end

    // ---------------- result register ----------------
    logic                take_reg;
    logic [ADDR_W-1:0]   new_pc_reg;
    logic [ADDR_W-1:0]   new_sp_reg;
    logic [COUNT_W-1:0]  push_high_reg;
    logic [COUNT_W-1:0]  push_low_reg;
    logic                enable_reg;
    logic                halted_reg;
    logic [COUNT_W-1:0]  timer_value_reg;
    logic [COUNT_W-1:0]  divider_value_reg;
    logic [IRQ_W-1:0]    pending_out_reg;

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            take_reg          <= take;
            new_pc_reg        <= take ? vector : s1_pc_reg;
            new_sp_reg        <= take ? s1_sp_reg - 16'd2 : s1_sp_reg;
            push_high_reg     <= take ? s1_pc_reg[ADDR_W-1:COUNT_W] : '0;
            push_low_reg      <= take ? s1_pc_reg[COUNT_W-1:0] : '0;
            enable_reg        <= s1_ime_reg && !take;
            // any enabled pending request wakes the core, served or not
            halted_reg        <= s1_halt_reg && !(|active);
            timer_value_reg   <= timer_status.timer_count;
            divider_value_reg <= timer_status.divider_count;
            pending_out_reg   <= pending_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign take_interrupt = take_reg;
    assign new_pc         = new_pc_reg;
    assign new_sp         = new_sp_reg;
    assign push_high      = push_high_reg;
    assign push_low       = push_low_reg;
    assign enable_out     = enable_reg;
    assign halted_out     = halted_reg;
    assign timer_value    = timer_value_reg;
    assign divider_value  = divider_value_reg;
    assign pending_out    = pending_out_reg;

    // ---------------- assertions ----------------
    a_service_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && take_reg |-> !enable_reg && !halted_reg)
        else $error("service left master enable or halt set");

    a_vector_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && take_reg |-> new_pc_reg[2:0] == 3'b000 && new_pc_reg >= 16'h0040
                                      && new_pc_reg <= 16'h0060)
        else $error("serviced vector out of range");

    a_no_push_without_service: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !take_reg |-> push_high_reg == '0 && push_low_reg == '0)
        else $error("push bytes set without service");

    a_word_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held word did not reach the result register");

endmodule
